>>> hdl/gjo_pkg.sv
// ----------------------------------------------------------------------------
// Gyro joystick offset package
// Shared payload types, register indexes and fixed-point constants.
// ----------------------------------------------------------------------------
package gjo_pkg;

  // Fraction bits of the filtered rate, in raw LSB units.
  localparam int EMA_FRACTION_BITS = 8;

  // Raw sample and stick widths.
  localparam int RAW_W  = 16;
  localparam int DIFF_W = RAW_W + 1;
  localparam int LIM_W  = 15;

  // Dead zone: 10 * |d| < 328 holds exactly when |d| <= 32.
  localparam int DEAD_NUM = 328;
  localparam int DEAD_MAX = (DEAD_NUM - 1) / 10;

  // Filter coefficients, alpha = 0.85 on the old value.
  localparam int EMA_KEEP = 85;
  localparam int EMA_NEW  = 15;
  localparam int EMA_DEN  = 100;

  // Output sensitivities in hundredths.
  localparam int SENS_X_NUM = 85;
  localparam int SENS_Y_NUM = 60;
  localparam int SENS_W     = 7;

  // 200 * 16.4 * 100 = 328000 = 5125 * 2^6.
  localparam int SCALE_DEN  = 328000;
  localparam int SCALE_POW2 = 6;
  localparam int SCALE_ODD  = SCALE_DEN / (1 << SCALE_POW2);

  // Filter state: target is d << F, so magnitude stays below 2^(16 + F).
  localparam int FILT_W = DIFF_W + EMA_FRACTION_BITS;
  localparam int MAG_W  = FILT_W - 1;

  // Filter numerator magnitude: 100 * |f| < 2^(MAG_W + 7).
  localparam int EMA_DEN_LOG = $clog2(EMA_DEN);
  localparam int NUM_W       = MAG_W + EMA_DEN_LOG;
  localparam int NUM_S       = NUM_W + 1;
  localparam int EMA_SHIFT   = NUM_W + EMA_DEN_LOG;
  localparam longint unsigned EMA_RCP =
    ((64'd1 << EMA_SHIFT) + 64'(EMA_DEN) - 64'd1) / 64'(EMA_DEN);

  // Scale path: |f| * L, then * sens and >> (F + 6), always below 2^32.
  localparam int FL_W       = MAG_W + LIM_W;
  localparam int SCL_SHIFT  = EMA_FRACTION_BITS + SCALE_POW2;
  localparam int SCALED_W   = 32;
  localparam int SCL_LOG    = $clog2(SCALE_ODD);
  localparam int SCL_RSHIFT = SCALED_W + SCL_LOG;
  localparam longint unsigned SCL_RCP =
    ((64'd1 << SCL_RSHIFT) + 64'(SCALE_ODD) - 64'd1) / 64'(SCALE_ODD);
  localparam int Q_W        = SCALED_W - SCL_LOG + 1;

  // Shared multiplier operand widths.
  localparam int MUL_A_W = (NUM_W > SCALED_W) ? NUM_W : SCALED_W;
  localparam int MUL_B_W = (NUM_W + 1 > SCALED_W + 1) ? NUM_W + 1 : SCALED_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // Queue between front and back.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_X = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_Y = 2'd2;

  localparam logic [LIM_W-1:0] LIMIT_RESET = 15'd2047;

  typedef struct packed {
    logic signed [RAW_W-1:0] rate_x_raw;
    logic signed [RAW_W-1:0] rate_y_raw;
    logic signed [RAW_W-1:0] stick_x;
    logic signed [RAW_W-1:0] stick_y;
    logic                    bypass;
  } in_item_t;

  typedef struct packed {
    logic signed [RAW_W-1:0] out_x;
    logic signed [RAW_W-1:0] out_y;
    logic signed [RAW_W-1:0] offset_x;
    logic signed [RAW_W-1:0] offset_y;
  } out_item_t;

  // Classified item as it waits in the queue.
  typedef struct packed {
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [RAW_W-1:0]  stick_x;
    logic signed [RAW_W-1:0]  stick_y;
    logic                     bypass;
  } work_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

>>> hdl/gjo_front.sv
// ----------------------------------------------------------------------------
// Gyro joystick offset front end
// Accepts input beats, removes the bias and applies the dead zone.
// ----------------------------------------------------------------------------
module gjo_front (
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  gjo_pkg::in_item_t          in_data_i,
  input  logic signed [15:0]         bias_x_i,
  input  logic signed [15:0]         bias_y_i,
  input  gjo_pkg::q_stat_t           q_stat_i,
  output logic                       push_o,
  output gjo_pkg::work_t             work_o
);
  import gjo_pkg::*;

  logic signed [DIFF_W-1:0] diff_x;
  logic signed [DIFF_W-1:0] diff_y;
  logic        [DIFF_W-1:0] abs_x;
  logic        [DIFF_W-1:0] abs_y;

  // Hold off the source while the queue is full.
  assign in_stall_o = q_stat_i.full;
  assign push_o     = in_valid_i && !q_stat_i.full;

  // Bias removal in 17 bits, which never overflows.
  assign diff_x = DIFF_W'(in_data_i.rate_x_raw) - DIFF_W'(bias_x_i);
  assign diff_y = DIFF_W'(in_data_i.rate_y_raw) - DIFF_W'(bias_y_i);

  assign abs_x = diff_x[DIFF_W-1] ? DIFF_W'(-diff_x) : DIFF_W'(diff_x);
  assign abs_y = diff_y[DIFF_W-1] ? DIFF_W'(-diff_y) : DIFF_W'(diff_y);

  // Rates below 2 deg/s count as no motion.
  always_comb begin
    work_o.dx      = (abs_x <= DIFF_W'(DEAD_MAX)) ? '0 : diff_x;
    work_o.dy      = (abs_y <= DIFF_W'(DEAD_MAX)) ? '0 : diff_y;
    work_o.stick_x = in_data_i.stick_x;
    work_o.stick_y = in_data_i.stick_y;
    work_o.bypass  = in_data_i.bypass;
  end

endmodule

>>> hdl/gjo_queue.sv
// ----------------------------------------------------------------------------
// Gyro joystick offset queue
// Short FIFO that decouples the front end from the arithmetic back end.
// ----------------------------------------------------------------------------
module gjo_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  gjo_pkg::work_t   push_data_i,
  input  logic             pop_i,
  output gjo_pkg::work_t   pop_data_o,
  output gjo_pkg::q_stat_t stat_o
);
  import gjo_pkg::*;

  work_t                slot_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [Q_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0]   cnt_q, cnt_d;
  logic                 do_push;
  logic                 do_pop;

  assign stat_o.full  = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign pop_data_o   = slot_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  // The fill count never runs past the depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= Q_CNT_W'(Q_DEPTH))
    else $error("queue count exceeds depth");

  // Read and write pointers only meet when the queue is empty or full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ptr_q == rd_ptr_q) |-> (stat_o.empty || stat_o.full))
    else $error("queue pointers disagree with count");

endmodule

>>> hdl/gjo_back.sv
// ----------------------------------------------------------------------------
// Gyro joystick offset back end
// Sequencer around one shared multiplier: filter update, scaling, output.
// ----------------------------------------------------------------------------
module gjo_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  gjo_pkg::q_stat_t     q_stat_i,
  input  gjo_pkg::work_t       q_data_i,
  output logic                 q_pop_o,
  input  logic [14:0]          limit_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output gjo_pkg::out_item_t   out_data_o
);
  import gjo_pkg::*;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EMA  = 3'd1;
  localparam logic [2:0] ST_FILT = 3'd2;
  localparam logic [2:0] ST_FL   = 3'd3;
  localparam logic [2:0] ST_SENS = 3'd4;
  localparam logic [2:0] ST_RCP  = 3'd5;
  localparam logic [2:0] ST_OFS  = 3'd6;
  localparam logic [2:0] ST_DONE = 3'd7;

  localparam logic signed [NUM_S-1:0] EMA_KEEP_C = NUM_S'(EMA_KEEP);
  localparam logic signed [NUM_S-1:0] EMA_NEW_C  = NUM_S'(EMA_NEW);

  logic [2:0]               state_q, state_d;
  logic                     axis_q, axis_d;
  work_t                    work_q;
  logic signed [FILT_W-1:0] filt_x_q, filt_y_q;
  logic signed [15:0]       held_x_q, held_y_q;
  logic [PROD_W-1:0]        prod_q;
  logic                     sign_q;
  logic [SCALED_W-1:0]      scaled_q;
  logic                     out_valid_q;
  out_item_t                out_q;

  logic signed [FILT_W-1:0] f_cur;
  logic signed [DIFF_W-1:0] d_cur;
  logic signed [NUM_S-1:0]  ema_num;
  logic signed [NUM_S-1:0]  ema_abs;
  logic [FILT_W-1:0]        f_abs;
  logic [MUL_A_W-1:0]       mul_a;
  logic [MUL_B_W-1:0]       mul_b;
  logic [PROD_W-1:0]        prod_d;
  logic [MAG_W-1:0]         f_mag_new;
  logic signed [FILT_W-1:0] f_new;
  logic [SENS_W-1:0]        sens;
  logic [FL_W+SENS_W-1:0]   sens_prod;
  logic [Q_W-1:0]           q_mag;
  logic [LIM_W-1:0]         sat_mag;
  logic signed [15:0]       ofs_new;
  logic                     out_free;
  out_item_t                result;

  // Clamp stick plus offset to the limit.
  function automatic logic signed [15:0] sat_add(input logic signed [15:0] a,
                                                 input logic signed [15:0] b,
                                                 input logic [14:0]        lim);
    logic signed [16:0] sum;
    logic signed [16:0] lim_s;
    sum   = 17'(a) + 17'(b);
    lim_s = $signed({2'b00, lim});
    if (sum > lim_s) begin
      sat_add = $signed({1'b0, lim});
    end else if (sum < -lim_s) begin
      sat_add = -$signed({1'b0, lim});
    end else begin
      sat_add = sum[15:0];
    end
  endfunction

  // Operands of the axis in work.
  assign f_cur = axis_q ? filt_y_q : filt_x_q;
  assign d_cur = axis_q ? work_q.dy : work_q.dx;

  // Filter numerator 85 * f + 15 * (d << F) and its magnitude.
  assign ema_num = NUM_S'(f_cur) * EMA_KEEP_C
                 + (NUM_S'(d_cur) <<< EMA_FRACTION_BITS) * EMA_NEW_C;
  assign ema_abs = ema_num[NUM_S-1] ? -ema_num : ema_num;
  assign f_abs   = f_cur[FILT_W-1] ? FILT_W'(-f_cur) : FILT_W'(f_cur);

  // Shared multiplier, operands chosen by the sequencer step.
  always_comb begin
    case (state_q)
      ST_EMA: begin
        mul_a = MUL_A_W'(ema_abs[NUM_W-1:0]);
        mul_b = MUL_B_W'(EMA_RCP);
      end
      ST_FL: begin
        mul_a = MUL_A_W'(f_abs[MAG_W-1:0]);
        mul_b = MUL_B_W'(limit_i);
      end
      ST_RCP: begin
        mul_a = MUL_A_W'(scaled_q);
        mul_b = MUL_B_W'(SCL_RCP);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Quotient of the filter division, signed back toward zero.
  assign f_mag_new = prod_q[EMA_SHIFT +: MAG_W];
  assign f_new     = sign_q ? -$signed({1'b0, f_mag_new}) : $signed({1'b0, f_mag_new});

  // The x filter drives offset_y, the y filter drives offset_x.
  assign sens      = axis_q ? SENS_W'(SENS_X_NUM) : SENS_W'(SENS_Y_NUM);
  assign sens_prod = (FL_W + SENS_W)'(prod_q[FL_W-1:0]) * (FL_W + SENS_W)'(sens);

  // Scaled offset, saturated to the limit.
  assign q_mag   = prod_q[SCL_RSHIFT +: Q_W];
  assign sat_mag = (q_mag > Q_W'(limit_i)) ? limit_i : q_mag[LIM_W-1:0];
  assign ofs_new = sign_q ? -$signed({1'b0, sat_mag}) : $signed({1'b0, sat_mag});

  // Result beat; bypass passes the stick and shows the held offsets.
  always_comb begin
    result.offset_x = held_x_q;
    result.offset_y = held_y_q;
    if (work_q.bypass) begin
      result.out_x = work_q.stick_x;
      result.out_y = work_q.stick_y;
    end else begin
      result.out_x = sat_add(work_q.stick_x, held_x_q, limit_i);
      result.out_y = sat_add(work_q.stick_y, held_y_q, limit_i);
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign q_pop_o  = (state_q == ST_IDLE) && !q_stat_i.empty;

  // Step sequencing.
  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    case (state_q)
      ST_IDLE: begin
        if (!q_stat_i.empty) begin
          axis_d  = 1'b0;
          state_d = q_data_i.bypass ? ST_DONE : ST_EMA;
        end
      end
      ST_EMA:  state_d = ST_FILT;
      ST_FILT: state_d = ST_FL;
      ST_FL:   state_d = ST_SENS;
      ST_SENS: state_d = ST_RCP;
      ST_RCP:  state_d = ST_OFS;
      ST_OFS: begin
        if (axis_q) begin
          state_d = ST_DONE;
        end else begin
          axis_d  = 1'b1;
          state_d = ST_EMA;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      axis_q      <= 1'b0;
      filt_x_q    <= '0;
      filt_y_q    <= '0;
      held_x_q    <= '0;
      held_y_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
      if (state_q == ST_FILT) begin
        if (axis_q) begin
          filt_y_q <= f_new;
        end else begin
          filt_x_q <= f_new;
        end
      end
      if (state_q == ST_OFS) begin
        if (axis_q) begin
          held_x_q <= ofs_new;
        end else begin
          held_y_q <= ofs_new;
        end
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (q_pop_o) begin
      work_q <= q_data_i;
    end
    if (state_q == ST_EMA) begin
      sign_q <= ema_num[NUM_S-1];
    end
    if (state_q == ST_FL) begin
      sign_q <= f_cur[FILT_W-1];
    end
    if (state_q == ST_SENS) begin
      scaled_q <= sens_prod[SCL_SHIFT +: SCALED_W];
    end
    if (state_q == ST_DONE && out_free) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A waiting item is always picked up from idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && !q_stat_i.empty) |=> (state_q != ST_IDLE))
    else $error("queued item not started");

  // Finishing with a free output slot presents a beat and returns to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_free) |=> (out_valid_q && state_q == ST_IDLE))
    else $error("result beat not presented");

  // Filter state only changes in its own update step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_FILT) |=> ($stable(filt_x_q) && $stable(filt_y_q)))
    else $error("filter state changed outside update step");

endmodule

>>> hdl/gyro_rate_to_joystick_offset_unit.sv
// ----------------------------------------------------------------------------
// Gyro rate to joystick offset unit
// Bias removal, dead zone, EMA filter and scaled stick offset per gyro sample.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake         | Beat contents
//  --------+-----------+-------------------+------------------------------------
//  in      | input     | valid / stall     | rates x/y, stick x/y, bypass
//  out     | output    | valid / stall     | out x/y, offset x/y
//  cfg     | input     | valid / ready     | register index, 16-bit write data
//
//  A filtered sample makes two passes of six steps through the shared
//  multiplier in the back end, after it is picked up and before it is
//  emitted. A bypass sample goes straight from pick-up to emit.
//  The two-entry queue keeps taking input beats while the back end works, until it is full.
//  The result register holds a beat while out_stall_i is high.
//  Reset clears filter state and held offsets; no clearing pass is needed.
//
module gyro_rate_to_joystick_offset_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  gjo_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output gjo_pkg::out_item_t  out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i
);
  import gjo_pkg::*;

  logic [LIM_W-1:0]   limit_q;
  logic signed [15:0] bias_x_q;
  logic signed [15:0] bias_y_q;
  q_stat_t            q_stat;
  logic               push;
  work_t              push_data;
  work_t              pop_data;
  logic               pop;

  // Configuration registers, always ready.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= LIMIT_RESET;
      bias_x_q <= '0;
      bias_y_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_LIMIT:  limit_q  <= cfg_data_i[LIM_W-1:0];
        CFG_BIAS_X: bias_x_q <= $signed(cfg_data_i);
        CFG_BIAS_Y: bias_y_q <= $signed(cfg_data_i);
        default: begin
        end
      endcase
    end
  end

  gjo_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .bias_x_i   (bias_x_q),
    .bias_y_i   (bias_y_q),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .work_o     (push_data)
  );

  gjo_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (q_stat)
  );

  gjo_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .q_data_i    (pop_data),
    .q_pop_o     (pop),
    .limit_i     (limit_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> sim/gjo_stick_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gyro joystick offset checker
// Watches the config, gyro and result channels of the offset unit, predicts
// every result beat from its own copy of the filter state, and compares.
// ----------------------------------------------------------------------------
module gjo_stick_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  gjo_pkg::in_item_t   in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  gjo_pkg::out_item_t  out_data_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i,
  input  logic                run_done_i,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  checked_o
);
  import gjo_pkg::*;

  localparam int MAX_PRINTS = 40;

  // Shadow copy of the registers and the filter state.
  logic [LIM_W-1:0]         limit_q;
  logic signed [RAW_W-1:0]  bias_x_q;
  logic signed [RAW_W-1:0]  bias_y_q;
  logic signed [FILT_W-1:0] filt_x_q;
  logic signed [FILT_W-1:0] filt_y_q;
  logic signed [RAW_W-1:0]  held_x_q;
  logic signed [RAW_W-1:0]  held_y_q;

  out_item_t predicted_stick_q[$];
  out_item_t want_beat;
  int        fail_count = 0;
  int        results_checked = 0;
  bit        leftovers_done;

  assign fail_count_o = fail_count;
  assign checked_o    = results_checked;

  task automatic report_mismatch(string msg);
    fail_count++;
    if (fail_count <= MAX_PRINTS) $display("%0t ns  mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic signed [15:0] got,
                             logic signed [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("beat %0d %s got %0d expected %0d",
                                results_checked, name, got, want));
  endtask

  function automatic longint clamp_to_limit(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Rates below 2 deg/s, that is 10 * |d| < 328, count as no rotation.
  function automatic longint zero_small_rate(longint d);
    longint mag;
    mag = (d < 0) ? -d : d;
    return (mag * 10 < DEAD_NUM) ? 64'sd0 : d;
  endfunction

  // One EMA step; SystemVerilog division truncates toward zero.
  function automatic longint ema_next(longint f, longint d);
    longint target;
    target = d * (64'sd1 <<< EMA_FRACTION_BITS);
    return (EMA_KEEP * f + EMA_NEW * target) / EMA_DEN;
  endfunction

  function automatic longint rate_to_offset(longint f, longint lim, longint sens);
    longint den;
    den = 64'(SCALE_DEN) * (64'sd1 <<< EMA_FRACTION_BITS);
    return clamp_to_limit((f * lim * sens) / den, lim);
  endfunction

  // Advances the shadow state by one gyro beat and returns its result.
  function automatic out_item_t filter_and_offset(in_item_t beat);
    longint    lim;
    longint    fx;
    longint    fy;
    out_item_t res;
    lim = longint'(limit_q);
    if (beat.bypass) begin
      res.out_x = beat.stick_x;
      res.out_y = beat.stick_y;
    end else begin
      fx = ema_next(longint'(filt_x_q),
                    zero_small_rate(longint'(beat.rate_x_raw) - longint'(bias_x_q)));
      fy = ema_next(longint'(filt_y_q),
                    zero_small_rate(longint'(beat.rate_y_raw) - longint'(bias_y_q)));
      filt_x_q  = FILT_W'(fx);
      filt_y_q  = FILT_W'(fy);
      // Axes are swapped: x offset follows the y rate.
      held_x_q  = RAW_W'(rate_to_offset(fy, lim, SENS_X_NUM));
      held_y_q  = RAW_W'(rate_to_offset(fx, lim, SENS_Y_NUM));
      res.out_x = RAW_W'(clamp_to_limit(longint'(beat.stick_x) + longint'(held_x_q), lim));
      res.out_y = RAW_W'(clamp_to_limit(longint'(beat.stick_y) + longint'(held_y_q), lim));
    end
    res.offset_x = held_x_q;
    res.offset_y = held_y_q;
    return res;
  endfunction

  // Registers and predictions follow the accepted beats; results are
  // compared against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q        = LIMIT_RESET;
      bias_x_q       = '0;
      bias_y_q       = '0;
      filt_x_q       = '0;
      filt_y_q       = '0;
      held_x_q       = '0;
      held_y_q       = '0;
      leftovers_done = 1'b0;
      predicted_stick_q.delete();
      pending_o     <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_LIMIT:  limit_q  = cfg_data_i[LIM_W-1:0];
          CFG_BIAS_X: bias_x_q = cfg_data_i;
          CFG_BIAS_Y: bias_y_q = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) predicted_stick_q.push_back(filter_and_offset(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        if (predicted_stick_q.size() == 0) begin
          report_mismatch("result beat with no prediction waiting");
        end else begin
          want_beat = predicted_stick_q.pop_front();
          check_field("out_x", out_data_i.out_x, want_beat.out_x);
          check_field("out_y", out_data_i.out_y, want_beat.out_y);
          check_field("offset_x", out_data_i.offset_x, want_beat.offset_x);
          check_field("offset_y", out_data_i.offset_y, want_beat.offset_y);
          results_checked++;
        end
      end
      if (run_done_i && !leftovers_done) begin
        leftovers_done = 1'b1;
        if (predicted_stick_q.size() != 0)
          report_mismatch($sformatf("%0d predicted beats never arrived",
                                    predicted_stick_q.size()));
      end
      pending_o <= predicted_stick_q.size();
    end
  end

endmodule

>>> sim/gyro_rate_to_joystick_offset_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gyro rate to joystick offset unit testbench
// Drives directed and random gyro beats through several register settings
// with random idling on both channels; the checker predicts and compares.
// ----------------------------------------------------------------------------
module gyro_rate_to_joystick_offset_unit_tb;
  import gjo_pkg::*;

  localparam int WATCHDOG_LIMIT   = 5000;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES     = 40;
  localparam int RANDOM_PHASES    = 6;
  localparam int PHASE_ITEMS      = 150;

  // Index that maps to no register; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        run_done = 1'b0;

  int fail_count;
  int pending;
  int checked;

  // Stimulus bookkeeping.
  logic signed [15:0] cur_bias_x = '0;
  logic signed [15:0] cur_bias_y = '0;
  logic signed [15:0] turn_x = '0;
  logic signed [15:0] turn_y = '0;
  bit tx_idling = 1'b1;
  bit rx_idling = 1'b1;
  bit hold_request = 1'b0;
  int items_sent = 0;
  int bypass_sent = 0;
  int cfg_writes = 0;
  int settings_used = 1;
  int long_holds = 0;
  int quiet_cycles = 0;

  gyro_rate_to_joystick_offset_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  gjo_stick_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .run_done_i   (run_done),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Ends the run when no beat moves on any channel for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles", quiet_cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side: random stall bursts, quiet stretches, and one long hold on request.
  initial begin
    int n;
    forever begin
      if (hold_request) begin
        out_stall <= 1'b1;
        for (n = 0; n < LONG_HOLD_CYCLES; n++) @(posedge clk);
        hold_request = 1'b0;
        long_holds++;
      end else if (rx_idling && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  function automatic in_item_t gyro_beat(int rx, int ry, int sx, int sy, bit byp);
    in_item_t b;
    b.rate_x_raw = 16'(rx);
    b.rate_y_raw = 16'(ry);
    b.stick_x    = 16'(sx);
    b.stick_y    = 16'(sy);
    b.bypass     = byp;
    return b;
  endfunction

  // Mostly rates around the bias (dead zone) or a steady turn, some full range.
  function automatic logic signed [15:0] pick_rate(logic signed [15:0] bias,
                                                   logic signed [15:0] turn);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return 16'(int'(bias) + int'($urandom_range(0, 160)) - 80);
    if (sel < 7) return 16'(int'(bias) + int'(turn) + int'($urandom_range(0, 512)) - 256);
    return 16'($urandom);
  endfunction

  function automatic logic signed [15:0] pick_stick();
    case ($urandom_range(0, 11))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'sh8001;
      3:       return 16'sh0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_item_t random_beat();
    in_item_t b;
    b.rate_x_raw = pick_rate(cur_bias_x, turn_x);
    b.rate_y_raw = pick_rate(cur_bias_y, turn_y);
    b.stick_x    = pick_stick();
    b.stick_y    = pick_stick();
    b.bypass     = ($urandom_range(0, 5) == 0);
    return b;
  endfunction

  // Offers one gyro beat, sometimes after an idle burst, and waits for acceptance.
  task automatic send_beat(in_item_t b);
    if (tx_idling && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (b.bypass) bypass_sent++;
  endtask

  // Stops offering and waits until every predicted result beat has arrived.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_writes++;
  endtask

  // Writes all three registers back to back; bit 15 of the limit beat is junk.
  task automatic set_config(logic [14:0] lim, logic signed [15:0] bx,
                            logic signed [15:0] by, bit poke_unmapped);
    write_reg(CFG_LIMIT, {1'($urandom_range(0, 1)), lim});
    write_reg(CFG_BIAS_X, bx);
    write_reg(CFG_BIAS_Y, by);
    if (poke_unmapped) write_reg(CFG_UNMAPPED, 16'($urandom));
    cfg_valid  <= 1'b0;
    cur_bias_x  = bx;
    cur_bias_y  = by;
    settings_used++;
  endtask

  initial begin
    logic [14:0]        lim;
    logic signed [15:0] bx;
    logic signed [15:0] by;
    int p;
    int i;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: bypass at reset, dead zone edges, build-up, stick extremes.
    send_beat(gyro_beat(0, 0, 0, 0, 1));
    send_beat(gyro_beat(32, -32, 100, -100, 0));
    send_beat(gyro_beat(33, -33, 100, -100, 0));
    repeat (3) send_beat(gyro_beat(32767, 32767, 0, 0, 0));
    send_beat(gyro_beat(32767, -32768, 32767, -32768, 0));
    send_beat(gyro_beat(-32768, -32768, -32768, 32767, 0));
    send_beat(gyro_beat(-32768, 32767, -32768, -32768, 1));
    send_beat(gyro_beat(0, 0, 32767, 32767, 1));
    wait_drained();

    // Widest limit with extreme biases: differences reach the full 17 bits.
    set_config(15'd32767, 16'sh7FFF, 16'sh8000, 1'b1);
    repeat (4) send_beat(gyro_beat(-32768, 32767, 0, 0, 0));
    send_beat(gyro_beat(32767, -32768, -32768, 32767, 0));
    send_beat(gyro_beat(0, 0, -32767, 32767, 0));
    wait_drained();

    // Limit change: a bypass beat still shows offsets held from the old limit.
    set_config(15'd1, 16'sh0000, 16'sh0000, 1'b0);
    send_beat(gyro_beat(0, 0, 5, -5, 1));
    send_beat(gyro_beat(32767, 32767, 32767, -32768, 0));
    wait_drained();

    // Zero limit forces every filtered output to zero.
    set_config(15'd0, 16'sh0000, 16'sh0000, 1'b0);
    send_beat(gyro_beat(32767, -32768, 1000, -1000, 0));
    send_beat(gyro_beat(0, 0, 1000, -1000, 1));
    send_beat(gyro_beat(-32768, 32767, -32768, 32767, 0));
    wait_drained();

    // Random phases, one register setting each; the last runs without idling.
    for (p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0) lim = 15'd32767;
      else if (p == 1) lim = 15'($urandom_range(1, 100));
      else begin
        case ($urandom_range(0, 2))
          0:       lim = 15'($urandom_range(1, 100));
          1:       lim = 15'd32767;
          default: lim = 15'($urandom_range(1, 32767));
        endcase
      end
      case ($urandom_range(0, 2))
        0: begin
          bx = 16'(int'($urandom_range(0, 400)) - 200);
          by = 16'(int'($urandom_range(0, 400)) - 200);
        end
        1: begin
          bx = 16'($urandom);
          by = 16'($urandom);
        end
        default: begin
          bx = '0;
          by = '0;
        end
      endcase
      set_config(lim, bx, by, p == 2);
      turn_x    = 16'(int'($urandom_range(0, 16000)) - 8000);
      turn_y    = 16'(int'($urandom_range(0, 16000)) - 8000);
      tx_idling = (p != RANDOM_PHASES - 1);
      rx_idling = (p != RANDOM_PHASES - 1);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        // Long receiver hold while gyro beats keep coming, so the unit backs up.
        if (p == 1 && i == 20) hold_request = 1'b1;
        // Sender pause until the unit has delivered everything.
        if (p == 2 && i == PHASE_ITEMS / 2) wait_drained();
        send_beat(random_beat());
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    run_done <= 1'b1;
    repeat (2) @(posedge clk);

    $display("Run covered %0d gyro beats (%0d in bypass) under %0d register settings",
             items_sent, bypass_sent, settings_used);
    $display("with %0d register writes; %0d result beats compared, %0d long receiver hold(s).",
             cfg_writes, checked, long_holds);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
